// ===== design/tcf_pkg.sv =====
// Shared types and constants for the tile cache directory.
package tcf_pkg;

  localparam int CACHE_SLOTS = 16;
  localparam int MAX_TILES   = 4096;
  localparam int TILE_PIXELS = 256;

  localparam int SLOT_W     = $clog2(CACHE_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int TILE_W     = 12;
  localparam int REG_W      = 13;
  localparam int PIX_W      = 16;
  localparam int TILE_SHIFT = $clog2(TILE_PIXELS);
  localparam int CELL_W     = PIX_W - TILE_SHIFT;
  localparam int PROD_W     = CELL_W + REG_W;
  localparam int IDX_W      = PROD_W + 1;

  // register indexes
  localparam logic REG_TILE_LIMIT    = 1'b0;
  localparam logic REG_TILES_PER_ROW = 1'b1;

  // commands
  localparam logic [2:0] CMD_LOCK    = 3'd0;
  localparam logic [2:0] CMD_PROBE   = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_FLUSH   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_LOCKED   = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_FLUSHED  = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_CHECK,
    OP_WALK,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/tile_cache_fifo_with_locks.sv =====
// Top level of the tile cache directory.
//
//  channel | direction | content
//  s_*     | in        | tuser: command; tdata: point_x, point_y, tile_number, release_slot
//  m_*     | out       | tuser: status; tdata: slot, evicted, evicted_tile
//  cfg_*   | in        | register write: 0 tile limit, 1 tiles_per_row
//
// An item steps through load, multiply, check and drive (S_IDLE, S_MUL, S_CHECK, S_DONE);
// the result is registered on the drive step, and the next beat is taken only back in S_IDLE.
// An insert of a new tile into a full cache adds a walk of the queue, one queue entry per cycle of the walk.
// Synchronous reset; no clearing pass, the tile map is the tag compare over the slots.
// A waiting result does not block the next beat; a stalled output holds the sequencer.
module tile_cache_fifo_with_locks
  import tcf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,   // point_x, point_y, tile_number, release_slot
  input  logic [2:0]       s_tuser,   // command
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // slot, evicted, evicted_tile
  output logic [2:0]       m_tuser,   // status
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== design/tcf_ctrl.sv =====
// Sequencer for the tile cache directory.
module tcf_ctrl
  import tcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = stat.need_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        if (stat.walk_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== design/tcf_dp.sv =====
// Datapath: slot table, insertion queue, lock mask and result register.
module tcf_dp
  import tcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  input  logic [55:0]       s_tdata,
  input  logic [2:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic [2:0]        m_tuser,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat
);

  logic [REG_W-1:0]  tile_limit, tiles_per_row;
  logic [2:0]        cmd_r;
  logic [PIX_W-1:0]  px_r, py_r;
  logic [TILE_W-1:0] tnum_r;
  logic [4:0]        rel_r;
  logic [PROD_W-1:0] prod;

  logic [TILE_W-1:0]      slot_tile   [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] slot_valid;
  logic [CNT_W-1:0]       slots_filled;
  logic [TILE_W-1:0]      order_queue [CACHE_SLOTS];
  logic [SLOT_W-1:0]      order_head;
  logic [CNT_W-1:0]       order_count;
  logic [CACHE_SLOTS-1:0] lock_mask;
  logic [CNT_W-1:0]       steps;

  logic [2:0]        res_status;
  logic [4:0]        res_slot;
  logic              res_ev;
  logic [TILE_W-1:0] res_evt;

  logic [IDX_W-1:0]  idx;
  logic              idx_ok, tnum_ok;
  logic [TILE_W-1:0] key, q_head;
  logic              cam_hit;
  logic [SLOT_W-1:0] cam_slot;
  logic [SLOT_W-1:0] tail;
  logic              walk_empty;

  assign idx     = IDX_W'(prod) + IDX_W'(px_r[PIX_W-1:TILE_SHIFT]);
  assign idx_ok  = (idx < IDX_W'(tile_limit)) && (idx < IDX_W'(MAX_TILES));
  assign tnum_ok = (REG_W'(tnum_r) < tile_limit) && (REG_W'(tnum_r) < REG_W'(MAX_TILES));
  assign q_head  = order_queue[order_head];
  assign tail    = order_head + order_count[SLOT_W-1:0];
  assign walk_empty = (steps == '0) || (order_count == '0);

  always_comb begin
    if (cmd.op == OP_WALK)         key = q_head;
    else if (cmd_r == CMD_INSERT)  key = tnum_r;
    else                           key = idx[TILE_W-1:0];
  end

  // the map from tile to slot is the set of valid slots holding that tile
  always_comb begin
    cam_hit  = 1'b0;
    cam_slot = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (slot_valid[i] && slot_tile[i] == key) begin
        cam_hit  = 1'b1;
        cam_slot = SLOT_W'(i);
      end
    end
  end

  assign stat.need_walk = (cmd_r == CMD_INSERT) && tnum_ok && !cam_hit &&
                          (slots_filled == CNT_W'(CACHE_SLOTS));
  assign stat.walk_done = walk_empty || (cam_hit && !lock_mask[cam_slot]);
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_limit    <= REG_W'(4096);
      tiles_per_row <= REG_W'(64);
      slot_valid    <= '0;
      slots_filled  <= '0;
      order_head    <= '0;
      order_count   <= '0;
      lock_mask     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TILE_LIMIT:    tile_limit    <= cfg_data;
          REG_TILES_PER_ROW: tiles_per_row <= cfg_data;
          default: ;
        endcase
      end
      if (m_tready && cmd.op != OP_OUT) m_tvalid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          cmd_r  <= s_tuser;
          px_r   <= s_tdata[15:0];
          py_r   <= s_tdata[31:16];
          tnum_r <= s_tdata[43:32];
          rel_r  <= s_tdata[48:44];
        end
        OP_MUL: prod <= py_r[PIX_W-1:TILE_SHIFT] * tiles_per_row;
        OP_CHECK: begin
          res_status <= ST_RANGE;
          res_slot   <= '0;
          res_ev     <= 1'b0;
          res_evt    <= '0;
          steps      <= order_count;
          case (cmd_r) inside
            CMD_LOCK, CMD_PROBE: begin
              if (idx_ok) begin
                if (cam_hit) begin
                  res_status <= ST_HIT;
                  res_slot   <= 5'(cam_slot);
                  if (cmd_r == CMD_LOCK) lock_mask[cam_slot] <= 1'b1;
                end else begin
                  res_status <= ST_MISS;
                end
              end
            end
            CMD_INSERT: begin
              if (tnum_ok) begin
                if (cam_hit) begin
                  res_status <= ST_HIT;
                  res_slot   <= 5'(cam_slot);
                end else if (slots_filled != CNT_W'(CACHE_SLOTS)) begin
                  // take the next free slot
                  res_status <= ST_INSERTED;
                  res_slot   <= 5'(slots_filled);
                  slot_tile[slots_filled[SLOT_W-1:0]]  <= tnum_r;
                  slot_valid[slots_filled[SLOT_W-1:0]] <= 1'b1;
                  slots_filled       <= slots_filled + 1'b1;
                  order_queue[tail]  <= tnum_r;
                  order_count        <= order_count + 1'b1;
                end
              end
            end
            CMD_RELEASE: begin
              res_status <= ST_RELEASED;
              res_slot   <= rel_r;
              if (rel_r < 5'(CACHE_SLOTS)) lock_mask[rel_r[SLOT_W-1:0]] <= 1'b0;
            end
            CMD_FLUSH: begin
              res_status   <= ST_FLUSHED;
              slot_valid   <= '0;
              slots_filled <= '0;
              order_head   <= '0;
              order_count  <= '0;
            end
            default: ;
          endcase
        end
        OP_WALK: begin
          if (walk_empty) begin
            res_status <= ST_LOCKED;
          end else begin
            steps      <= steps - 1'b1;
            order_head <= order_head + 1'b1;
            if (!cam_hit) begin
              // drop a stale entry
              order_count <= order_count - 1'b1;
            end else if (lock_mask[cam_slot]) begin
              // rotate a locked entry to the back
              order_queue[tail] <= q_head;
            end else begin
              slot_tile[cam_slot] <= tnum_r;
              order_queue[tail]   <= tnum_r;
              res_status <= ST_INSERTED;
              res_slot   <= 5'(cam_slot);
              res_ev     <= 1'b1;
              res_evt    <= q_head;
            end
          end
        end
        OP_OUT: begin
          m_tvalid <= 1'b1;
          m_tuser  <= res_status;
          m_tdata  <= {6'b0, res_evt, res_ev, res_slot};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/tcf_checker.sv =====
// Port-level checks for the tile cache directory, bound to the top level.
module tcf_checker
  import tcf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_evict_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tuser == ST_INSERTED)
    else $error("eviction flagged on a non-insert result");

  a_evict_tile: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[17:6] == '0)
    else $error("evicted tile set without eviction");

endmodule

bind tile_cache_fifo_with_locks tcf_checker u_tcf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the tile cache directory: directed and random command streams.
`timescale 1ns / 1ps

module tb
  import tcf_pkg::*;
;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [REG_W-1:0] cfg_data = '0;

  tile_cache_fifo_with_locks dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic evicted;
    logic [11:0] evicted_tile;
  } lookup_result_t;

  // directory model
  logic [12:0] cnt_reg, row_reg;
  logic [4:0] map_slot [MAX_TILES];
  logic map_ok [MAX_TILES];
  logic [11:0] held_tile [CACHE_SLOTS];
  logic held_ok [CACHE_SLOTS];
  int filled;
  logic [11:0] order_q [$];
  logic [CACHE_SLOTS-1:0] pins;

  lookup_result_t pending_results [$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit rx_random = 1;

  function automatic bit in_range(longint idx);
    return idx < cnt_reg && idx < MAX_TILES;
  endfunction

  function automatic void clear_directory();
    for (int i = 0; i < MAX_TILES; i++) begin
      map_ok[i] = 0;
      map_slot[i] = 0;
    end
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      held_ok[i] = 0;
      held_tile[i] = 0;
    end
    filled = 0;
    order_q.delete();
  endfunction

  // walk the order queue once; locked entries go to the back
  function automatic int pick_victim(output logic [11:0] vt);
    int steps;
    logic [11:0] t;
    int s;
    steps = order_q.size();
    vt = 0;
    for (int k = 0; k < steps; k++) begin
      t = order_q[0];
      order_q.delete(0);
      if (!map_ok[t]) continue;
      s = int'(map_slot[t]);
      if (!held_ok[s] || held_tile[s] != t) continue;
      if (pins[s]) begin
        order_q.insert(order_q.size(), t);
        continue;
      end
      map_ok[t] = 0;
      held_ok[s] = 0;
      vt = t;
      return s;
    end
    return -1;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [2:0] cmd, logic [15:0] px,
                                                   logic [15:0] py, logic [11:0] tn,
                                                   logic [4:0] rel);
    lookup_result_t r;
    longint idx;
    int s;
    logic [11:0] vt;
    r = '0;
    r.status = ST_RANGE;
    if (cmd == CMD_LOCK || cmd == CMD_PROBE) begin
      idx = longint'(py / TILE_PIXELS) * row_reg + px / TILE_PIXELS;
      if (in_range(idx)) begin
        if (map_ok[idx]) begin
          r.status = ST_HIT;
          r.slot = map_slot[idx];
          if (cmd == CMD_LOCK) pins[map_slot[idx]] = 1;
        end else begin
          r.status = ST_MISS;
        end
      end
    end else if (cmd == CMD_INSERT) begin
      if (in_range(tn)) begin
        if (map_ok[tn]) begin
          r.status = ST_HIT;
          r.slot = map_slot[tn];
        end else begin
          if (filled < CACHE_SLOTS) begin
            s = filled;
            filled++;
          end else begin
            s = pick_victim(vt);
            if (s >= 0) begin
              r.evicted = 1;
              r.evicted_tile = vt;
            end
          end
          if (s < 0) begin
            r.status = ST_LOCKED;
          end else begin
            r.status = ST_INSERTED;
            r.slot = 5'(s);
            held_tile[s] = tn;
            held_ok[s] = 1;
            map_slot[tn] = 5'(s);
            map_ok[tn] = 1;
            if (order_q.size() < CACHE_SLOTS) order_q.insert(order_q.size(), tn);
          end
        end
      end
    end else if (cmd == CMD_RELEASE) begin
      r.status = ST_RELEASED;
      r.slot = rel;
      if (rel < CACHE_SLOTS) pins[rel] = 0;
    end else if (cmd == CMD_FLUSH) begin
      r.status = ST_FLUSHED;
      clear_directory();
    end
    return r;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stalls, a long hold-off when requested, or always ready when rx_random is off
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 0;
        hold_off--;
      end else if (rx_random && $urandom_range(0, 5) != 0) begin
        w = $urandom_range(0, 5);
        m_tready <= (w < 3);
      end else begin
        m_tready <= 1;
      end
    end
  end

  // result checker
  initial begin
    lookup_result_t got, want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[4:0], m_tdata[5], m_tdata[17:6]};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.slot !== want.slot)
            $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
          if (got.evicted !== want.evicted)
            $display("%0t: evicted exp %0d got %0d", $time, want.evicted, got.evicted);
          if (got.evicted_tile !== want.evicted_tile)
            $display("%0t: evicted_tile exp %0d got %0d", $time, want.evicted_tile,
                     got.evicted_tile);
          if (got !== want) errors++;
        end
      end
    end
  end

  // valid stays up between back-to-back beats; drop it only for a gap
  task automatic send_cmd(logic [2:0] cmd, logic [15:0] px, logic [15:0] py,
                          logic [11:0] tn, logic [4:0] rel, bit gaps = 1);
    int w;
    w = gaps ? $urandom_range(0, 5) : 0;
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, rel, tn, py, px};
    pending_results.insert(pending_results.size(), predict_lookup(cmd, px, py, tn, rel));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_TILE_LIMIT) cnt_reg = val;
    else row_reg = val;
  endtask

  // point that lands on a tile at the current row width, else a random point
  task automatic send_tile_point(logic [2:0] cmd, int tile);
    int r, c;
    if (row_reg == 0) begin
      send_cmd(cmd, 16'($urandom), 16'($urandom), 12'd0, 5'd0);
    end else begin
      r = tile / row_reg;
      c = tile % row_reg;
      if (r > 255 || c > 255) send_cmd(cmd, 16'($urandom), 16'($urandom), 12'd0, 5'd0);
      else send_cmd(cmd, 16'(c * TILE_PIXELS + $urandom_range(0, 255)),
                    16'(r * TILE_PIXELS + $urandom_range(0, 255)), 12'd0, 5'd0);
    end
  endtask

  task automatic test_directed();
    send_cmd(CMD_PROBE, 0, 0, 0, 0);
    send_cmd(CMD_PROBE, 16'hFFFF, 16'hFFFF, 0, 0);
    send_cmd(CMD_INSERT, 0, 0, 12'hFFF, 0);
    for (int i = 0; i < 16; i++) send_cmd(CMD_INSERT, 0, 0, 12'(i), 0);
    send_cmd(CMD_INSERT, 0, 0, 3, 0);
    send_cmd(CMD_LOCK, 0, 0, 0, 0);
    send_cmd(CMD_INSERT, 0, 0, 100, 0);
    send_cmd(CMD_RELEASE, 0, 0, 0, 5'd31);
    send_cmd(CMD_RELEASE, 0, 0, 0, 0);
    send_cmd(3'd5, 0, 0, 0, 0);
    send_cmd(3'd7, 16'hFFFF, 16'hFFFF, 12'hFFF, 5'h1F);
    send_cmd(CMD_FLUSH, 0, 0, 0, 0);
  endtask

  task automatic test_all_locked();
    for (int i = 0; i < 16; i++) send_cmd(CMD_INSERT, 0, 0, 12'(i), 0);
    for (int i = 0; i < 16; i++) send_tile_point(CMD_LOCK, i);
    send_cmd(CMD_INSERT, 0, 0, 200, 0);
    send_cmd(CMD_RELEASE, 0, 0, 0, 7);
    send_cmd(CMD_INSERT, 0, 0, 201, 0);
    for (int i = 0; i < 16; i++) send_cmd(CMD_RELEASE, 0, 0, 0, 5'(i));
    send_cmd(CMD_FLUSH, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    for (int i = 0; i < 20; i++) send_cmd(CMD_INSERT, 0, 0, 12'(300 + i), 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int c, t, span;
    span = (cnt_reg < 40) ? cnt_reg + 4 : 40;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      t = $urandom_range(0, span - 1);
      if (c < 35) send_cmd(CMD_INSERT, 0, 0, 12'(t), 0);
      else if (c < 55) send_tile_point(CMD_PROBE, t);
      else if (c < 70) send_tile_point(CMD_LOCK, t);
      else if (c < 84) send_cmd(CMD_RELEASE, 0, 0, 0, 5'($urandom_range(0, 17)));
      else if (c < 86) send_cmd(CMD_FLUSH, 0, 0, 0, 0);
      else if (c < 88) send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                                12'($urandom), 5'($urandom));
      else if (c < 94) send_cmd(CMD_INSERT, 0, 0, 12'($urandom), 0);
      else send_cmd(3'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 0, 0);
    end
  endtask

  initial begin
    cnt_reg = 13'd4096;
    row_reg = 13'd64;
    pins = '0;
    clear_directory();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_all_locked();
    test_backpressure();
    test_random(200);
    write_reg(REG_TILE_LIMIT, 13'd1);
    write_reg(REG_TILES_PER_ROW, 13'd1);
    test_random(100);
    write_reg(REG_TILE_LIMIT, 13'd30);
    write_reg(REG_TILES_PER_ROW, 13'd4096);
    test_random(100);
    write_reg(REG_TILE_LIMIT, 13'd4096);
    write_reg(REG_TILES_PER_ROW, 13'd5);
    test_random(200);
    rx_random = 0;
    test_random(50);
    rx_random = 1;
    write_reg(REG_TILE_LIMIT, 13'd8191);
    write_reg(REG_TILES_PER_ROW, 13'd0);
    test_random(100);
    wait_drained();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== tile_cache_fifo_with_locks.f =====
design/tcf_pkg.sv
design/tcf_ctrl.sv
design/tcf_dp.sv
design/tile_cache_fifo_with_locks.sv
design/tcf_checker.sv
tb/tb.sv
